/* hdl/uete_pkg.sv */
// uete_pkg: types and constants of the usb endpoint transfer engine
// field widths, command codes, endpoint record and beat layouts
// no dependencies; used by usb_endpoint_transfer_engine_core
`timescale 1ns / 1ps

package uete_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int EP_W     = 2;
   localparam int LEN_W    = 16;
   localparam int MPK_W    = 10;
   localparam int PBYTES_W = 10;
   localparam int SPACE_W  = 7;
   localparam int INFL_W   = 11;

   // inflight byte count saturates here
   localparam logic [INFL_W-1:0] INFLIGHT_MAX = 11'd2047;
   // a setup packet moves at most this many bytes
   localparam logic [PBYTES_W-1:0] SETUP_BYTES = 10'd8;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN        = 3'd0,
      CMD_START       = 3'd1,
      CMD_IN_DONE     = 3'd2,
      CMD_IN_REFILL   = 3'd3,
      CMD_OUT_PACKET  = 3'd4,
      CMD_STALL       = 3'd5,
      CMD_CLEAR_STALL = 3'd6
   } cmd_type;

   // transfer record of one endpoint and direction
   typedef struct packed {
      logic [LEN_W-1:0]  total;
      logic [LEN_W-1:0]  done;
      logic [INFL_W-1:0] infl;
      logic [MPK_W-1:0]  maxpkt;
      logic              tog;
      logic              stall;
   } rec_type;

   // request beat
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [EP_W-1:0]     endpoint;
      logic                direction;
      logic [LEN_W-1:0]    xfer_length;
      logic [MPK_W-1:0]    max_packet;
      logic [PBYTES_W-1:0] packet_bytes;
      logic [SPACE_W-1:0]  fifo_space;
      logic                acked;
      logic                rx_toggle;
      logic                rx_error;
      logic                rx_final;
      logic                is_setup;
   } req_type;

   // response beat
   typedef struct packed {
      logic [MPK_W-1:0] load_count;
      logic [LEN_W-1:0] byte_offset;
      logic             toggle_out;
      logic             tx_enable;
      logic             fifo_warn_on;
      logic             mark_last;
      logic             rx_enable;
      logic             flush;
      logic             xfer_done;
      logic [LEN_W-1:0] done_length;
      logic             setup_seen;
   } rsp_type;

endpackage

/* hdl/usb_endpoint_transfer_engine_core.sv */
// usb_endpoint_transfer_engine_core: per-endpoint transfer records, data toggle
// and fifo load planning for a usb device controller
// depends on uete_pkg
//
//   channel | ports            | handshake          | beat
//   --------+------------------+--------------------+-------------------------------
//   request | req_*            | req_valid/req_ready | one command for one endpoint
//   result  | rsp_*            | rsp_valid/rsp_ready | one answer per command
//
// each beat is registered on entry, worked through combinationally against the
// endpoint record and registered again on exit, one beat per cycle sustained while
// the result side is ready; the record update lands at the same edge as the result,
// so back-to-back beats on one endpoint see fresh state
// synchronous reset clears every record (toggles to DATA0) and both stages
// a stalled result holds the work stage; requests stop only once both are full
`timescale 1ns / 1ps

module usb_endpoint_transfer_engine_core #(
   parameter int ENDPOINTS  = 4,
   parameter int FIFO_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [uete_pkg::CMD_W-1:0]       req_cmd,
   input  logic [uete_pkg::EP_W-1:0]        req_endpoint,
   input  logic                             req_direction,
   input  logic [uete_pkg::LEN_W-1:0]       req_xfer_length,
   input  logic [uete_pkg::MPK_W-1:0]       req_max_packet,
   input  logic [uete_pkg::PBYTES_W-1:0]    req_packet_bytes,
   input  logic [uete_pkg::SPACE_W-1:0]     req_fifo_space,
   input  logic                             req_acked,
   input  logic                             req_rx_toggle,
   input  logic                             req_rx_error,
   input  logic                             req_rx_final,
   input  logic                             req_is_setup,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [uete_pkg::MPK_W-1:0]       rsp_load_count,
   output logic [uete_pkg::LEN_W-1:0]       rsp_byte_offset,
   output logic                             rsp_toggle_out,
   output logic                             rsp_tx_enable,
   output logic                             rsp_fifo_warn_on,
   output logic                             rsp_mark_last,
   output logic                             rsp_rx_enable,
   output logic                             rsp_flush,
   output logic                             rsp_xfer_done,
   output logic [uete_pkg::LEN_W-1:0]       rsp_done_length,
   output logic                             rsp_setup_seen
);

   import uete_pkg::*;

   localparam int EP_AW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

   // pipeline registers
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic    req_vld_ff;
   logic    rsp_vld_ff;
   logic    out_free;
   logic    adv;

   // endpoint records, one array per direction
   rec_type orec_ff [ENDPOINTS];
   rec_type irec_ff [ENDPOINTS];
   rec_type orec_in, irec_in;
   rec_type cur_o, cur_i;

   logic             ep_ok;
   logic [EP_AW-1:0] ep_idx;
   logic             is_ep0;
   cmd_type          cmd;
   logic [SPACE_W-1:0] spc;

   // fifo load planning on the IN record
   logic [LEN_W-1:0]   p_total, p_done;
   logic [INFL_W-1:0]  p_infl;
   logic               p_tog;
   logic [LEN_W-1:0]   ack_done;
   logic               ack_hit;
   logic [LEN_W-1:0]   pl_left;
   logic [MPK_W-1:0]   pl_room;
   logic [MPK_W-1:0]   pl_want;
   logic [SPACE_W-1:0] pl_load;
   logic [INFL_W:0]    pl_infl_sum;
   logic [INFL_W-1:0]  pl_infl;

   // receive take on the OUT record
   logic [LEN_W-1:0]    tk_left;
   logic [PBYTES_W-1:0] tk_take;
   logic [LEN_W-1:0]    tk_done;
   logic [INFL_W:0]     tk_infl_sum;
   logic [INFL_W-1:0]   tk_infl;
   logic                fin_hit;
   logic                tog_match;

   // handshake
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign adv       = req_vld_ff && out_free;
   assign req_ready = !req_vld_ff || out_free;
   assign rsp_valid = rsp_vld_ff;

   // request beat assembly
   always_comb begin
      req_in.cmd          = req_cmd;
      req_in.endpoint     = req_endpoint;
      req_in.direction    = req_direction;
      req_in.xfer_length  = req_xfer_length;
      req_in.max_packet   = req_max_packet;
      req_in.packet_bytes = req_packet_bytes;
      req_in.fifo_space   = req_fifo_space;
      req_in.acked        = req_acked;
      req_in.rx_toggle    = req_rx_toggle;
      req_in.rx_error     = req_rx_error;
      req_in.rx_final     = req_rx_final;
      req_in.is_setup     = req_is_setup;
   end

   // record read
   assign ep_ok  = (int'(req_ff.endpoint) < ENDPOINTS);
   assign ep_idx = ep_ok ? EP_AW'(req_ff.endpoint) : '0;
   assign cur_o  = orec_ff[ep_idx];
   assign cur_i  = irec_ff[ep_idx];
   assign is_ep0 = (req_ff.endpoint == '0);
   assign cmd    = cmd_type'(req_ff.cmd);
   assign spc    = (int'(req_ff.fifo_space) > FIFO_BYTES) ? SPACE_W'(FIFO_BYTES)
                                                           : req_ff.fifo_space;

   // IN record as seen by the load planner
   assign ack_done = cur_i.done + LEN_W'(cur_i.infl);
   assign ack_hit  = (ack_done == cur_i.total);

   always_comb begin
      p_total = cur_i.total;
      p_done  = cur_i.done;
      p_infl  = cur_i.infl;
      p_tog   = cur_i.tog;
      priority if (cmd == CMD_START) begin
         p_total = req_ff.xfer_length;
         p_done  = '0;
         p_infl  = '0;
      end else if (cmd == CMD_IN_DONE) begin
         p_infl = '0;
         if (req_ff.acked) begin
            p_done = ack_done;
            p_tog  = ~cur_i.tog;
         end
      end else begin
      end
   end

   // load = min(total - done, maxpkt - inflight, fifo space)
   always_comb begin
      pl_left     = (p_total > p_done) ? (p_total - p_done) : '0;
      pl_room     = ({1'b0, cur_i.maxpkt} > p_infl) ?
                    MPK_W'({1'b0, cur_i.maxpkt} - p_infl) : '0;
      pl_want     = (pl_left < LEN_W'(pl_room)) ? MPK_W'(pl_left) : pl_room;
      pl_load     = (pl_want < MPK_W'(spc)) ? SPACE_W'(pl_want) : spc;
      pl_infl_sum = (INFL_W+1)'(p_infl) + (INFL_W+1)'(pl_load);
      pl_infl     = (pl_infl_sum > (INFL_W+1)'(INFLIGHT_MAX)) ? INFLIGHT_MAX
                                                             : INFL_W'(pl_infl_sum);
   end

   // receive take and completion check
   always_comb begin
      tk_left     = (cur_o.total > cur_o.done) ? (cur_o.total - cur_o.done) : '0;
      tk_take     = (LEN_W'(req_ff.packet_bytes) < tk_left) ? req_ff.packet_bytes
                                                             : PBYTES_W'(tk_left);
      tk_done     = cur_o.done + LEN_W'(tk_take);
      tk_infl_sum = (INFL_W+1)'(cur_o.infl) + (INFL_W+1)'(tk_take);
      tk_infl     = (tk_infl_sum > (INFL_W+1)'(INFLIGHT_MAX)) ? INFLIGHT_MAX
                                                             : INFL_W'(tk_infl_sum);
      fin_hit     = (cur_o.total == tk_done) || (tk_infl < INFL_W'(cur_o.maxpkt));
      tog_match   = (req_ff.rx_toggle == cur_o.tog);
   end

   // command decode and record update
   always_comb begin
      orec_in = cur_o;
      irec_in = cur_i;
      rsp_in  = '0;
      if (ep_ok) begin
         unique case (cmd)
            CMD_OPEN: begin
               if (req_ff.direction) begin
                  irec_in.maxpkt = req_ff.max_packet;
                  irec_in.tog    = 1'b0;
               end else begin
                  orec_in.maxpkt = req_ff.max_packet;
                  orec_in.tog    = 1'b0;
               end
            end
            CMD_START, CMD_IN_DONE, CMD_IN_REFILL: begin
               if (cmd == CMD_START && !req_ff.direction) begin
                  orec_in.total    = req_ff.xfer_length;
                  orec_in.done     = '0;
                  orec_in.infl     = '0;
                  rsp_in.rx_enable = 1'b1;
               end else if (cmd == CMD_IN_DONE && req_ff.acked && ack_hit) begin
                  // last packet acknowledged: transfer complete
                  irec_in.done       = ack_done;
                  irec_in.infl       = '0;
                  irec_in.tog        = ~cur_i.tog;
                  rsp_in.xfer_done   = 1'b1;
                  rsp_in.done_length = cur_i.total;
               end else begin
                  // plan the next fifo load
                  irec_in.total       = p_total;
                  irec_in.done        = p_done;
                  irec_in.infl        = pl_infl;
                  irec_in.tog         = p_tog;
                  rsp_in.load_count   = MPK_W'(pl_load);
                  rsp_in.byte_offset  = p_done + LEN_W'(p_infl);
                  rsp_in.toggle_out   = p_tog;
                  rsp_in.tx_enable    = 1'b1;
                  rsp_in.fifo_warn_on = !is_ep0 && (pl_want > MPK_W'(pl_load));
                  rsp_in.mark_last    = !is_ep0 && !(pl_want > MPK_W'(pl_load));
               end
            end
            CMD_OUT_PACKET: begin
               if (is_ep0 && req_ff.is_setup) begin
                  // setup resets both endpoint-zero records to DATA1
                  rsp_in.load_count = (req_ff.packet_bytes < SETUP_BYTES) ?
                                      req_ff.packet_bytes : SETUP_BYTES;
                  rsp_in.toggle_out = 1'b1;
                  rsp_in.setup_seen = 1'b1;
                  orec_in.stall     = 1'b0;
                  irec_in.stall     = 1'b0;
                  orec_in.tog       = 1'b1;
                  irec_in.tog       = 1'b1;
               end else if ((is_ep0 && !tog_match) || (!is_ep0 && req_ff.rx_error)) begin
                  rsp_in.flush = 1'b1;
               end else begin
                  // move received bytes into the buffer
                  rsp_in.load_count  = tk_take;
                  rsp_in.byte_offset = cur_o.done;
                  orec_in.done       = tk_done;
                  orec_in.infl       = tk_infl;
                  if (is_ep0 || req_ff.rx_final) begin
                     if (!tog_match) begin
                        rsp_in.flush = 1'b1;
                     end else begin
                        orec_in.tog = ~cur_o.tog;
                        if (fin_hit) begin
                           rsp_in.xfer_done   = 1'b1;
                           rsp_in.done_length = tk_done;
                        end else begin
                           orec_in.infl     = '0;
                           rsp_in.rx_enable = 1'b1;
                        end
                     end
                  end
               end
            end
            CMD_STALL: begin
               if (req_ff.direction) begin
                  irec_in.stall     = 1'b1;
                  rsp_in.tx_enable  = 1'b1;
                  rsp_in.toggle_out = cur_i.tog;
                  rsp_in.mark_last  = !is_ep0;
               end else begin
                  orec_in.stall    = 1'b1;
                  rsp_in.rx_enable = 1'b1;
               end
            end
            CMD_CLEAR_STALL: begin
               if (req_ff.direction) begin
                  irec_in.tog   = 1'b0;
                  irec_in.stall = 1'b0;
               end else begin
                  orec_in.tog   = 1'b0;
                  orec_in.stall = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state and records
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k < ENDPOINTS; k++) begin
            orec_ff[k] <= '0;
            irec_ff[k] <= '0;
         end
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (out_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (adv && ep_ok) begin
            orec_ff[ep_idx] <= orec_in;
            irec_ff[ep_idx] <= irec_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // result beat
   assign rsp_load_count   = rsp_ff.load_count;
   assign rsp_byte_offset  = rsp_ff.byte_offset;
   assign rsp_toggle_out   = rsp_ff.toggle_out;
   assign rsp_tx_enable    = rsp_ff.tx_enable;
   assign rsp_fifo_warn_on = rsp_ff.fifo_warn_on;
   assign rsp_mark_last    = rsp_ff.mark_last;
   assign rsp_rx_enable    = rsp_ff.rx_enable;
   assign rsp_flush        = rsp_ff.flush;
   assign rsp_xfer_done    = rsp_ff.xfer_done;
   assign rsp_done_length  = rsp_ff.done_length;
   assign rsp_setup_seen   = rsp_ff.setup_seen;

endmodule

/* test/usb_endpoint_transfer_engine_core_tb.sv */
// usb_endpoint_transfer_engine_core_tb: self-checking bench for the endpoint transfer engine
// drives directed and random endpoint commands, predicts every answer, checks them in order
// depends on uete_pkg and usb_endpoint_transfer_engine_core
`timescale 1ns / 1ps

module usb_endpoint_transfer_engine_core_tb;
   import uete_pkg::*;

   localparam int ENDPOINTS    = 4;
   localparam int FIFO_BYTES   = 64;
   localparam int ITEM_TARGET  = 1950;
   localparam int CALM_TAIL    = 200;
   localparam int DRAIN_CYCLES = 10;
   // command code that the engine must ignore
   localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd          = '0;
   logic [EP_W-1:0]     req_endpoint     = '0;
   logic                req_direction    = 1'b0;
   logic [LEN_W-1:0]    req_xfer_length  = '0;
   logic [MPK_W-1:0]    req_max_packet   = '0;
   logic [PBYTES_W-1:0] req_packet_bytes = '0;
   logic [SPACE_W-1:0]  req_fifo_space   = '0;
   logic                req_acked        = 1'b0;
   logic                req_rx_toggle    = 1'b0;
   logic                req_rx_error     = 1'b0;
   logic                req_rx_final     = 1'b0;
   logic                req_is_setup     = 1'b0;

   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [MPK_W-1:0]    rsp_load_count;
   logic [LEN_W-1:0]    rsp_byte_offset;
   logic                rsp_toggle_out;
   logic                rsp_tx_enable;
   logic                rsp_fifo_warn_on;
   logic                rsp_mark_last;
   logic                rsp_rx_enable;
   logic                rsp_flush;
   logic                rsp_xfer_done;
   logic [LEN_W-1:0]    rsp_done_length;
   logic                rsp_setup_seen;

   usb_endpoint_transfer_engine_core #(
      .ENDPOINTS  (ENDPOINTS),
      .FIFO_BYTES (FIFO_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_endpoint     (req_endpoint),
      .req_direction    (req_direction),
      .req_xfer_length  (req_xfer_length),
      .req_max_packet   (req_max_packet),
      .req_packet_bytes (req_packet_bytes),
      .req_fifo_space   (req_fifo_space),
      .req_acked        (req_acked),
      .req_rx_toggle    (req_rx_toggle),
      .req_rx_error     (req_rx_error),
      .req_rx_final     (req_rx_final),
      .req_is_setup     (req_is_setup),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_load_count   (rsp_load_count),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_toggle_out   (rsp_toggle_out),
      .rsp_tx_enable    (rsp_tx_enable),
      .rsp_fifo_warn_on (rsp_fifo_warn_on),
      .rsp_mark_last    (rsp_mark_last),
      .rsp_rx_enable    (rsp_rx_enable),
      .rsp_flush        (rsp_flush),
      .rsp_xfer_done    (rsp_xfer_done),
      .rsp_done_length  (rsp_done_length),
      .rsp_setup_seen   (rsp_setup_seen)
   );

   // commands waiting to be driven, answers waiting to come back
   req_type pending_beats [$];
   rsp_type due_answers [$];
   req_type on_wire = '0;

   // shadow of the endpoint records, index endpoint*2+direction
   rec_type ep_rec [2*ENDPOINTS];

   int beats_planned    = 0;
   int beats_taken      = 0;
   int answers_checked  = 0;
   int completions_seen = 0;
   int flushes_seen     = 0;
   int setups_seen      = 0;
   int mismatch_count   = 0;
   int src_odds         = 20;
   int sink_odds        = 20;
   int src_hold         = 0;
   int sink_hold        = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int sat_sub(int a, int b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic int lesser(int a, int b);
      return (a < b) ? a : b;
   endfunction

   // fifo load for the in record: bounded by bytes left, packet room and fifo space
   function automatic void plan_fifo_load(int idx, int ep, int space, inout rsp_type ans);
      int want;
      int load;
      want = lesser(sat_sub(ep_rec[idx].total, ep_rec[idx].done),
                    sat_sub(ep_rec[idx].maxpkt, ep_rec[idx].infl));
      load = lesser(want, lesser(space, FIFO_BYTES));
      ans.load_count  = MPK_W'(load);
      ans.byte_offset = LEN_W'(ep_rec[idx].done + ep_rec[idx].infl);
      ans.toggle_out  = ep_rec[idx].tog;
      ans.tx_enable   = 1'b1;
      ep_rec[idx].infl = INFL_W'(lesser(ep_rec[idx].infl + load, INFLIGHT_MAX));
      if (ep != 0) begin
         if (want > load) ans.fifo_warn_on = 1'b1;
         else ans.mark_last = 1'b1;
      end
   endfunction

   // received bytes go into the buffer at the acknowledged offset
   function automatic void take_rx_bytes(int idx, int bytes, inout rsp_type ans);
      int take;
      take = lesser(bytes, sat_sub(ep_rec[idx].total, ep_rec[idx].done));
      ans.load_count  = MPK_W'(take);
      ans.byte_offset = ep_rec[idx].done;
      ep_rec[idx].done = LEN_W'(ep_rec[idx].done + take);
      ep_rec[idx].infl = INFL_W'(lesser(ep_rec[idx].infl + take, INFLIGHT_MAX));
   endfunction

   // end of a good out packet: short packet or full length completes the transfer
   function automatic void close_rx_packet(int idx, inout rsp_type ans);
      ep_rec[idx].tog = ~ep_rec[idx].tog;
      if (ep_rec[idx].total == ep_rec[idx].done || ep_rec[idx].infl < ep_rec[idx].maxpkt) begin
         ans.xfer_done   = 1'b1;
         ans.done_length = ep_rec[idx].done;
      end else begin
         ep_rec[idx].infl = '0;
         ans.rx_enable    = 1'b1;
      end
   endfunction

   // expected answer of one command, updating the shadow records
   function automatic rsp_type answer_for(req_type b);
      rsp_type ans;
      int ep;
      int idx;
      int rout;
      int rin;
      ans  = '0;
      ep   = int'(b.endpoint);
      if (ep >= ENDPOINTS) return ans;
      idx  = ep * 2 + int'(b.direction);
      rout = ep * 2;
      rin  = ep * 2 + 1;
      case (b.cmd)
         CMD_OPEN: begin
            ep_rec[idx].maxpkt = b.max_packet;
            ep_rec[idx].tog    = 1'b0;
         end
         CMD_START: begin
            ep_rec[idx].total = b.xfer_length;
            ep_rec[idx].done  = '0;
            ep_rec[idx].infl  = '0;
            if (!b.direction) ans.rx_enable = 1'b1;
            else plan_fifo_load(idx, ep, int'(b.fifo_space), ans);
         end
         CMD_IN_DONE: begin
            if (b.acked) begin
               ep_rec[rin].done = LEN_W'(ep_rec[rin].done + ep_rec[rin].infl);
               ep_rec[rin].infl = '0;
               ep_rec[rin].tog  = ~ep_rec[rin].tog;
            end else begin
               ep_rec[rin].infl = '0;
            end
            if (b.acked && ep_rec[rin].done == ep_rec[rin].total) begin
               ans.xfer_done   = 1'b1;
               ans.done_length = ep_rec[rin].total;
            end else begin
               plan_fifo_load(rin, ep, int'(b.fifo_space), ans);
            end
         end
         CMD_IN_REFILL: plan_fifo_load(rin, ep, int'(b.fifo_space), ans);
         CMD_OUT_PACKET: begin
            if (ep == 0) begin
               if (b.is_setup) begin
                  ans.load_count   = (b.packet_bytes < SETUP_BYTES) ? b.packet_bytes : SETUP_BYTES;
                  ans.toggle_out   = 1'b1;
                  ans.setup_seen   = 1'b1;
                  ep_rec[rout].stall = 1'b0;
                  ep_rec[rin].stall  = 1'b0;
                  ep_rec[rout].tog   = 1'b1;
                  ep_rec[rin].tog    = 1'b1;
               end else if (b.rx_toggle != ep_rec[rout].tog) begin
                  ans.flush = 1'b1;
               end else begin
                  take_rx_bytes(rout, int'(b.packet_bytes), ans);
                  close_rx_packet(rout, ans);
               end
            end else if (b.rx_error) begin
               ans.flush = 1'b1;
            end else begin
               // bytes count even when the toggle turns out wrong
               take_rx_bytes(rout, int'(b.packet_bytes), ans);
               if (b.rx_final) begin
                  if (b.rx_toggle != ep_rec[rout].tog) ans.flush = 1'b1;
                  else close_rx_packet(rout, ans);
               end
            end
         end
         CMD_STALL: begin
            ep_rec[idx].stall = 1'b1;
            if (!b.direction) begin
               ans.rx_enable = 1'b1;
            end else begin
               ans.tx_enable  = 1'b1;
               ans.toggle_out = ep_rec[idx].tog;
               if (ep != 0) ans.mark_last = 1'b1;
            end
         end
         CMD_CLEAR_STALL: begin
            ep_rec[idx].tog   = 1'b0;
            ep_rec[idx].stall = 1'b0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic bit differs(string field, int want, int seen);
      if (want != seen)
         $display("time %0t: %s expected %0d actual %0d", $time, field, want, seen);
      return want != seen;
   endfunction

   task automatic check_answer(rsp_type want, rsp_type seen);
      bit bad;
      bad = 1'b0;
      bad |= differs("load_count", want.load_count, seen.load_count);
      bad |= differs("byte_offset", want.byte_offset, seen.byte_offset);
      bad |= differs("toggle_out", want.toggle_out, seen.toggle_out);
      bad |= differs("tx_enable", want.tx_enable, seen.tx_enable);
      bad |= differs("fifo_warn_on", want.fifo_warn_on, seen.fifo_warn_on);
      bad |= differs("mark_last", want.mark_last, seen.mark_last);
      bad |= differs("rx_enable", want.rx_enable, seen.rx_enable);
      bad |= differs("flush", want.flush, seen.flush);
      bad |= differs("xfer_done", want.xfer_done, seen.xfer_done);
      bad |= differs("done_length", want.done_length, seen.done_length);
      bad |= differs("setup_seen", want.setup_seen, seen.setup_seen);
      if (bad) mismatch_count++;
   endtask

   // command with random filler in the fields it does not use
   function automatic req_type blank_beat(logic [CMD_W-1:0] cmd, int ep, int dir);
      logic [63:0] noise;
      req_type     b;
      noise       = {$urandom, $urandom};
      b           = noise[$bits(req_type)-1:0];
      b.cmd       = cmd;
      b.endpoint  = EP_W'(ep);
      b.direction = dir[0];
      return b;
   endfunction

   task automatic push_beat(req_type b);
      pending_beats.push_back(b);
      beats_planned++;
   endtask

   function automatic logic [MPK_W-1:0] pick_maxpkt();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return MPK_W'(8 << $urandom_range(0, 3));
      if (r < 90) return MPK_W'($urandom_range(1, 200));
      return MPK_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return LEN_W'($urandom_range(0, 400));
      if (r < 95) return LEN_W'($urandom_range(0, 3000));
      return LEN_W'($urandom_range(0, 65535));
   endfunction

   // mostly a full or partly full fifo, now and then beyond its size
   function automatic logic [SPACE_W-1:0] pick_space();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return SPACE_W'(FIFO_BYTES);
      if (r < 92) return SPACE_W'($urandom_range(0, FIFO_BYTES));
      return SPACE_W'($urandom_range(FIFO_BYTES + 1, 127));
   endfunction

   // request driver: holds each beat until accepted, random gap bursts between beats
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_hold = 0;
      end else begin
         if (req_valid && req_ready) begin
            due_answers.push_back(answer_for(on_wire));
            beats_taken++;
         end
         if (!req_valid || req_ready) begin
            if (src_hold > 0) begin
               src_hold--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               on_wire = pending_beats.pop_front();
               req_valid        <= 1'b1;
               req_cmd          <= on_wire.cmd;
               req_endpoint     <= on_wire.endpoint;
               req_direction    <= on_wire.direction;
               req_xfer_length  <= on_wire.xfer_length;
               req_max_packet   <= on_wire.max_packet;
               req_packet_bytes <= on_wire.packet_bytes;
               req_fifo_space   <= on_wire.fifo_space;
               req_acked        <= on_wire.acked;
               req_rx_toggle    <= on_wire.rx_toggle;
               req_rx_error     <= on_wire.rx_error;
               req_rx_final     <= on_wire.rx_final;
               req_is_setup     <= on_wire.is_setup;
               if ($urandom_range(0, 99) < src_odds) src_hold = $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each accepted beat, stalls in random bursts
   always @(posedge clock) begin
      rsp_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_load_count, rsp_byte_offset, rsp_toggle_out, rsp_tx_enable,
                    rsp_fifo_warn_on, rsp_mark_last, rsp_rx_enable, rsp_flush,
                    rsp_xfer_done, rsp_done_length, rsp_setup_seen};
            if (due_answers.size() == 0) begin
               $display("time %0t: expected no answer, actual answer with load_count %0d",
                        $time, seen.load_count);
               mismatch_count++;
            end else begin
               check_answer(due_answers.pop_front(), seen);
            end
            answers_checked++;
            if (seen.xfer_done) completions_seen++;
            if (seen.flush) flushes_seen++;
            if (seen.setup_seen) setups_seen++;
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < sink_odds) sink_hold = $urandom_range(1, 16);
         end
      end
   end

   // stimulus and end of run
   initial begin
      req_type  b;
      int       ep;
      int       dir;
      int       r;
      int       mpk;
      logic     tog;
      foreach (ep_rec[i]) ep_rec[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored code with all ones
      b = '1;
      b.cmd = CMD_RESERVED;
      push_beat(b);
      // extreme packet sizes
      b = blank_beat(CMD_OPEN, 1, 1); b.max_packet = 10'd1023; push_beat(b);
      b = blank_beat(CMD_OPEN, 1, 0); b.max_packet = 10'd0; push_beat(b);
      b = blank_beat(CMD_OPEN, 2, 1); b.max_packet = 10'd64; push_beat(b);
      // longest in transfer, oversized and empty fifo space, nak then ack
      b = blank_beat(CMD_START, 1, 1);
      b.xfer_length = 16'hFFFF; b.fifo_space = 7'd127; push_beat(b);
      b = blank_beat(CMD_IN_REFILL, 1, 0); b.fifo_space = 7'd0; push_beat(b);
      b = blank_beat(CMD_IN_DONE, 1, 1); b.acked = 1'b0; b.fifo_space = 7'd64; push_beat(b);
      b = blank_beat(CMD_IN_DONE, 1, 0); b.acked = 1'b1; b.fifo_space = 7'd64; push_beat(b);
      // zero length in transfer completes on its first ack
      b = blank_beat(CMD_START, 2, 1); b.xfer_length = '0; b.fifo_space = 7'd64; push_beat(b);
      b = blank_beat(CMD_IN_DONE, 2, 1); b.acked = 1'b1; push_beat(b);
      // stall and clear
      b = blank_beat(CMD_STALL, 2, 1); push_beat(b);
      b = blank_beat(CMD_CLEAR_STALL, 2, 1); push_beat(b);
      b = blank_beat(CMD_STALL, 1, 0); push_beat(b);
      // out chunks up to inflight saturation, then toggle mismatch, error, good end
      b = blank_beat(CMD_START, 1, 0); b.xfer_length = 16'hFFFF; push_beat(b);
      repeat (3) begin
         b = blank_beat(CMD_OUT_PACKET, 1, 0);
         b.packet_bytes = 10'd1023; b.rx_error = 1'b0; b.rx_final = 1'b0;
         push_beat(b);
      end
      b = blank_beat(CMD_OUT_PACKET, 1, 0);
      b.packet_bytes = 10'd1023; b.rx_error = 1'b0; b.rx_final = 1'b1; b.rx_toggle = 1'b1;
      push_beat(b);
      b = blank_beat(CMD_OUT_PACKET, 1, 1);
      b.packet_bytes = 10'd5; b.rx_error = 1'b1; b.rx_final = 1'b1; push_beat(b);
      b = blank_beat(CMD_OUT_PACKET, 1, 0);
      b.packet_bytes = 10'd0; b.rx_error = 1'b0; b.rx_final = 1'b1; b.rx_toggle = 1'b0;
      push_beat(b);
      // setup packets: long one clamped, short one as is
      b = blank_beat(CMD_OUT_PACKET, 0, 0); b.is_setup = 1'b1; b.packet_bytes = 10'd1023;
      push_beat(b);
      b = blank_beat(CMD_OUT_PACKET, 0, 1); b.is_setup = 1'b1; b.packet_bytes = 10'd3;
      push_beat(b);
      // endpoint zero: wrong toggle after setup, then a good data packet ends the transfer
      b = blank_beat(CMD_OUT_PACKET, 0, 0); b.is_setup = 1'b0; b.rx_toggle = 1'b0;
      push_beat(b);
      b = blank_beat(CMD_START, 0, 0); b.xfer_length = 16'd10; push_beat(b);
      b = blank_beat(CMD_OUT_PACKET, 0, 0);
      b.is_setup = 1'b0; b.rx_toggle = 1'b1; b.packet_bytes = 10'd20; push_beat(b);
      b = blank_beat(CMD_STALL, 0, 1); push_beat(b);

      // random transfers, each built from the records once all earlier beats are in
      while (beats_planned < ITEM_TARGET) begin
         while (beats_taken != beats_planned) @(negedge clock);
         if (beats_planned > ITEM_TARGET - CALM_TAIL || $urandom_range(0, 3) == 0) begin
            src_odds  = 0;
            sink_odds = 0;
         end else begin
            src_odds  = $urandom_range(3, 30);
            sink_odds = $urandom_range(3, 30);
         end
         r  = $urandom_range(0, 99);
         ep = $urandom_range(0, ENDPOINTS - 1);
         if (r < 35) begin
            // in transfer: start, then acks, naks and refills
            if ($urandom_range(0, 99) < 75) begin
               b = blank_beat(CMD_OPEN, ep, 1); b.max_packet = pick_maxpkt(); push_beat(b);
            end
            b = blank_beat(CMD_START, ep, 1);
            b.xfer_length = pick_length(); b.fifo_space = pick_space(); push_beat(b);
            repeat ($urandom_range(2, 14)) begin
               r = $urandom_range(0, 99);
               b = blank_beat((r < 72) ? CMD_IN_DONE : CMD_IN_REFILL, ep, $urandom_range(0, 1));
               b.acked = (r < 55);
               b.fifo_space = pick_space();
               push_beat(b);
            end
         end else if (r < 78) begin
            // out transfer, mostly with the expected data toggle
            tog = ep_rec[2*ep].tog;
            mpk = int'(ep_rec[2*ep].maxpkt);
            if ($urandom_range(0, 99) < 70) begin
               b = blank_beat(CMD_OPEN, ep, 0);
               b.max_packet = pick_maxpkt();
               mpk = int'(b.max_packet);
               push_beat(b);
               tog = 1'b0;
            end
            if (ep == 0 && $urandom_range(0, 99) < 40) begin
               b = blank_beat(CMD_OUT_PACKET, 0, $urandom_range(0, 1));
               b.is_setup = 1'b1;
               b.packet_bytes = PBYTES_W'($urandom_range(0, 12));
               push_beat(b);
               tog = 1'b1;
            end
            b = blank_beat(CMD_START, ep, 0); b.xfer_length = pick_length(); push_beat(b);
            repeat ($urandom_range(1, 10)) begin
               b = blank_beat(CMD_OUT_PACKET, ep, $urandom_range(0, 1));
               r = $urandom_range(0, 99);
               if (r < 60) b.packet_bytes = PBYTES_W'(mpk);
               else if (r < 90) b.packet_bytes = PBYTES_W'($urandom_range(0, mpk));
               else b.packet_bytes = PBYTES_W'($urandom_range(0, 1023));
               if (ep == 0) begin
                  b.is_setup = ($urandom_range(0, 99) < 8);
               end else begin
                  b.rx_error = ($urandom_range(0, 99) < 8);
                  b.rx_final = ($urandom_range(0, 99) < 75);
               end
               if (ep == 0 && b.is_setup) begin
                  tog = 1'b1;
               end else if (ep == 0 || (b.rx_final && !b.rx_error)) begin
                  if ($urandom_range(0, 99) < 85) begin
                     b.rx_toggle = tog;
                     tog = ~tog;
                  end else begin
                     b.rx_toggle = ~tog;
                  end
               end
               push_beat(b);
            end
         end else if (r < 90) begin
            // stall, usually cleared again
            dir = $urandom_range(0, 1);
            b = blank_beat(CMD_STALL, ep, dir); push_beat(b);
            if ($urandom_range(0, 99) < 70) begin
               b = blank_beat(CMD_CLEAR_STALL, ep, dir); push_beat(b);
            end
         end else begin
            // unstructured commands, reserved code included
            repeat ($urandom_range(1, 4)) begin
               b = blank_beat(CMD_W'($urandom_range(0, 7)), $urandom_range(0, ENDPOINTS - 1),
                              $urandom_range(0, 1));
               push_beat(b);
            end
         end
      end

      while (beats_taken != beats_planned) @(negedge clock);
      while (due_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d commands sent, %0d answers checked, %0d mismatched", beats_taken,
               answers_checked, mismatch_count);
      $display("seen: %0d completed transfers, %0d fifo flushes, %0d setup packets",
               completions_seen, flushes_seen, setups_seen);
      if (mismatch_count == 0) begin
         $display("usb_endpoint_transfer_engine_core_tb: PASS");
      end else begin
         $display("usb_endpoint_transfer_engine_core_tb: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("time %0t: timeout with %0d answers outstanding", $time, due_answers.size());
      $display("usb_endpoint_transfer_engine_core_tb: FAIL");
      $finish;
   end

endmodule
